// ----- hw/rtl/dqa_pkg.sv -----
// Shared types, constants and helper functions for the dual quaternion unit.
// Used by every module under hw/rtl; depends on nothing.
package dqa_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  // blend, squares and sum front end (4), root steps, divide prep (1), quotient steps, final (1)
  localparam int LERP_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int DQM_LAT    = 2;
  localparam int DQ_LAT     = 3 * DQM_LAT;
  localparam int DQ_PAD     = LERP_LAT - DQ_LAT;

  localparam logic [2:0] ACT_MUL       = 3'd0;
  localparam logic [2:0] ACT_XFORM     = 3'd1;
  localparam logic [2:0] ACT_LERP      = 3'd2;
  localparam logic [2:0] ACT_ROT_FIRST = 3'd3;
  localparam logic [2:0] ACT_TR_FIRST  = 3'd4;

  typedef logic [31:0] comp_t;
  typedef struct packed {comp_t w; comp_t z; comp_t y; comp_t x;} quat_t;
  typedef struct packed {quat_t d; quat_t r;} dquat_t;
  typedef struct packed {comp_t v; logic sat;} clamp_t;
  typedef struct packed {dquat_t q; logic sat;} dq_flag_t;

  function automatic clamp_t clamp32(input logic signed [67:0] v);
    clamp_t o;
    if (v > 68'sd2147483647) begin
      o.v = 32'h7FFF_FFFF;
      o.sat = 1'b1;
    end else if (v < -68'sd2147483648) begin
      o.v = 32'h8000_0000;
      o.sat = 1'b1;
    end else begin
      o.v = v[31:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

  function automatic clamp_t neg32(input comp_t c);
    logic signed [67:0] e;
    e = -(68'($signed(c)));
    return clamp32(e);
  endfunction

  // real part (-x,-y,-z,w), dual part (x,y,z,-w)
  function automatic dq_flag_t dconj(input dquat_t t);
    dq_flag_t o;
    clamp_t c;
    o.q = t;
    o.sat = 1'b0;
    c = neg32(t.r.x); o.q.r.x = c.v; o.sat |= c.sat;
    c = neg32(t.r.y); o.q.r.y = c.v; o.sat |= c.sat;
    c = neg32(t.r.z); o.q.r.z = c.v; o.sat |= c.sat;
    c = neg32(t.d.w); o.q.d.w = c.v; o.sat |= c.sat;
    return o;
  endfunction

  // Hamilton product component k from rounded partial products r[i][j] = a_i*b_j
  function automatic logic signed [65:0] ham(input logic signed [63:0] r [4][4], input int k);
    logic signed [65:0] s;
    unique case (k)
      0: s = r[3][0] + r[0][3] + r[1][2] - r[2][1];
      1: s = r[3][1] - r[0][2] + r[1][3] + r[2][0];
      2: s = r[3][2] + r[0][1] - r[1][0] + r[2][3];
      default: s = r[3][3] - r[0][0] - r[1][1] - r[2][2];
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/dqa_dq_mul.sv -----
// Two-stage dual quaternion multiplier: partial products, then round/sum/clamp.
// Depends on dqa_pkg.
module dqa_dq_mul #(
  parameter int FRAC_BITS = dqa_pkg::FRAC_BITS
) (
  input  logic            clk,
  input  logic            en,
  input  dqa_pkg::dquat_t a,
  input  dqa_pkg::dquat_t b,
  output dqa_pkg::dquat_t res,
  output logic            sat
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prr [4][4];
  logic signed [63:0] prd [4][4];
  logic signed [63:0] pdr [4][4];
  logic signed [63:0] rrr [4][4];
  logic signed [63:0] rrd [4][4];
  logic signed [63:0] rdr [4][4];
  dqa_pkg::dquat_t    res_next;
  logic               sat_next;
  dqa_pkg::clamp_t    cr;
  dqa_pkg::clamp_t    cd;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prr[i][j] <= $signed(a.r[32*i +: 32]) * $signed(b.r[32*j +: 32]);
          prd[i][j] <= $signed(a.r[32*i +: 32]) * $signed(b.d[32*j +: 32]);
          pdr[i][j] <= $signed(a.d[32*i +: 32]) * $signed(b.r[32*j +: 32]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        rrr[i][j] = (prr[i][j] + HALF) >>> FRAC_BITS;
        rrd[i][j] = (prd[i][j] + HALF) >>> FRAC_BITS;
        rdr[i][j] = (pdr[i][j] + HALF) >>> FRAC_BITS;
      end
    end
    res_next = '0;
    sat_next = 1'b0;
    cr = '0;
    cd = '0;
    for (int k = 0; k < 4; k++) begin
      cr = dqa_pkg::clamp32(68'(dqa_pkg::ham(rrr, k)));
      cd = dqa_pkg::clamp32(68'(dqa_pkg::ham(rrd, k)) + 68'(dqa_pkg::ham(rdr, k)));
      res_next.r[32*k +: 32] = cr.v;
      res_next.d[32*k +: 32] = cd.v;
      sat_next = sat_next | cr.sat | cd.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      sat <= sat_next;
    end
  end

endmodule

// ----- hw/rtl/dqa_lerp.sv -----
// Lerp pipeline: weighted blend, squared length, pipelined integer root,
// eight-lane pipelined restoring divide and final clamp. Depends on dqa_pkg.
module dqa_lerp #(
  parameter int FRAC_BITS = dqa_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  dqa_pkg::dquat_t    a,
  input  dqa_pkg::dquat_t    b,
  input  logic signed [31:0] p,
  output dqa_pkg::dquat_t    res,
  output logic               sat,
  output logic               zl
);

  localparam int NS = dqa_pkg::SQRT_STEPS;
  localparam int ND = dqa_pkg::DIV_STEPS;
  localparam logic signed [33:0] ONE    = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] HALF66 = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [33:0] q;
  assign q = ONE - 34'(p);

  // stage 1: weighted products
  logic signed [65:0] pa [8];
  logic signed [63:0] pb [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        pa[k] <= q * $signed(a[32*k +: 32]);
        pb[k] <= p * $signed(b[32*k +: 32]);
      end
    end
  end

  // stage 2: round, sum, clamp
  dqa_pkg::comp_t  m1 [8];
  logic            ms1;
  dqa_pkg::comp_t  m1_next [8];
  logic            ms1_next;
  dqa_pkg::clamp_t cm;
  logic signed [65:0] ra;
  logic signed [63:0] rb;
  always_comb begin
    ms1_next = 1'b0;
    cm = '0;
    ra = '0;
    rb = '0;
    for (int k = 0; k < 8; k++) begin
      ra = (pa[k] + HALF66) >>> FRAC_BITS;
      rb = (pb[k] + HALF64) >>> FRAC_BITS;
      cm = dqa_pkg::clamp32(68'(ra) + 68'(rb));
      m1_next[k] = cm.v;
      ms1_next = ms1_next | cm.sat;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= m1_next;
      ms1 <= ms1_next;
    end
  end

  // stage 3: squares of the real part
  logic [63:0]    sq [4];
  dqa_pkg::comp_t m2 [8];
  logic           ms2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq[k] <= 64'($signed(m1[k]) * $signed(m1[k]));
      end
      m2  <= m1;
      ms2 <= ms1;
    end
  end

  // stage 4: saturating sum, seeds the root pipe
  logic [65:0]    ssum;
  logic [63:0]    sn    [NS+1];
  logic [35:0]    srem  [NS+1];
  logic [31:0]    sroot [NS+1];
  dqa_pkg::comp_t sm    [NS+1][8];
  logic           sms   [NS+1];
  assign ssum = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]) + 66'(sq[3]);
  always_ff @(posedge clk) begin
    if (en) begin
      sn[0]    <= (ssum[65:64] != 2'b00) ? '1 : ssum[63:0];
      srem[0]  <= '0;
      sroot[0] <= '0;
      sm[0]    <= m2;
      sms[0]   <= ms2;
    end
  end

  // one root bit per stage, two radicand bits consumed each time
  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    logic [35:0] rt;
    logic [35:0] tr;
    logic        ge;
    assign rt = {srem[g][33:0], sn[g][63:62]};
    assign tr = {2'b00, sroot[g], 2'b01};
    assign ge = rt >= tr;
    always_ff @(posedge clk) begin
      if (en) begin
        srem[g+1]  <= ge ? rt - tr : rt;
        sroot[g+1] <= {sroot[g][30:0], ge};
        sn[g+1]    <= {sn[g][61:0], 2'b00};
        sm[g+1]    <= sm[g];
        sms[g+1]   <= sms[g];
      end
    end
  end

  // divide prep: rounded numerator, overflow check against len << 32
  logic [31:0] dlen  [ND+1];
  logic        dzero [ND+1];
  logic        dms   [ND+1];
  logic        dneg  [ND+1][8];
  logic        dovf  [ND+1][8];
  logic [31:0] drem  [ND+1][8];
  logic [31:0] dlow  [ND+1][8];
  logic [31:0] dquo  [ND+1][8];

  for (genvar k = 0; k < 8; k++) begin : g_prep
    logic [31:0] c;
    logic [31:0] mag;
    logic [63:0] num;
    assign c   = sm[NS][k];
    assign mag = c[31] ? 32'(-c) : c;
    assign num = (64'(mag) << FRAC_BITS) + 64'(sroot[NS] >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        dneg[0][k] <= c[31];
        dovf[0][k] <= num >= {sroot[NS], 32'h0};
        drem[0][k] <= num[63:32];
        dlow[0][k] <= num[31:0];
        dquo[0][k] <= '0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dlen[0]  <= sroot[NS];
      dzero[0] <= sroot[NS] == '0;
      dms[0]   <= sms[NS];
    end
  end

  // one quotient bit per stage in each of the eight lanes
  for (genvar g = 0; g < ND; g++) begin : g_div
    for (genvar k = 0; k < 8; k++) begin : g_lane
      logic [32:0] rt;
      logic        ge;
      assign rt = {drem[g][k], dlow[g][k][31]};
      assign ge = rt >= {1'b0, dlen[g]};
      always_ff @(posedge clk) begin
        if (en) begin
          drem[g+1][k] <= ge ? 32'(rt - {1'b0, dlen[g]}) : rt[31:0];
          dlow[g+1][k] <= {dlow[g][k][30:0], 1'b0};
          dquo[g+1][k] <= {dquo[g][k][30:0], ge};
          dneg[g+1][k] <= dneg[g][k];
          dovf[g+1][k] <= dovf[g][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dlen[g+1]  <= dlen[g];
        dzero[g+1] <= dzero[g];
        dms[g+1]   <= dms[g];
      end
    end
  end

  // final: sign, clamp, zero length
  dqa_pkg::dquat_t res_next;
  logic            sat_next;
  logic            big;
  logic [31:0]     qv;
  always_comb begin
    res_next = '0;
    sat_next = dms[ND];
    big = 1'b0;
    qv = '0;
    for (int k = 0; k < 8; k++) begin
      qv = dquo[ND][k];
      if (dneg[ND][k]) begin
        big = dovf[ND][k] || (qv > 32'h8000_0000);
        res_next[32*k +: 32] = big ? 32'h8000_0000 : 32'(-qv);
      end else begin
        big = dovf[ND][k] || qv[31];
        res_next[32*k +: 32] = big ? 32'h7FFF_FFFF : qv;
      end
      sat_next = sat_next | big;
    end
    if (dzero[ND]) begin
      res_next = '0;
      sat_next = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
      sat <= sat_next;
      zl  <= dzero[ND];
    end
  end

endmodule

// ----- hw/rtl/dual_quaternion_arith_unit_core.sv -----
// Top level of the dual quaternion arithmetic unit.
// Depends on dqa_pkg, dqa_dq_mul and dqa_lerp.
//
// Usage:
//   Input channel: in_valid / in_stall with action, operands A and B (packed Q16.16
//   components) and proportion. A transaction is taken on a clock edge where
//   in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with the result, saturated and zero_length.
//   Every input transaction gives exactly one output transaction, in order.
// Depth: every action passes through the same number of registers. The lerp path sets it:
//   32 root stages and 32 quotient stages, one bit per stage. The multiply and
//   transform paths (three two-stage dual quaternion multipliers) are padded to match.
// Throughput: one transaction per cycle while the pipeline is not frozen by a stall.
// Stall: the pipeline advances as a whole; it freezes only while a result sits
//   in the output register and out_stall is high, and in_stall is raised then.
// Reset: clears the valid bits; data registers are not reset.
module dual_quaternion_arith_unit_core #(
  parameter int FRAC_BITS = dqa_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [63:0]        a_real_xy,
  input  logic [63:0]        a_real_zw,
  input  logic [63:0]        a_dual_xy,
  input  logic [63:0]        a_dual_zw,
  input  logic [63:0]        b_real_xy,
  input  logic [63:0]        b_real_zw,
  input  logic [63:0]        b_dual_xy,
  input  logic [63:0]        b_dual_zw,
  input  logic signed [31:0] proportion,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        res_real_xy,
  output logic [63:0]        res_real_zw,
  output logic [63:0]        res_dual_xy,
  output logic [63:0]        res_dual_zw,
  output logic               saturated,
  output logic               zero_length
);

  localparam int LL    = dqa_pkg::LERP_LAT;
  localparam int PAD   = dqa_pkg::DQ_PAD;
  localparam int TOTAL = LL + 1;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic             en;
  logic [TOTAL-1:0] vld;

  assign en        = !(vld[TOTAL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  dqa_pkg::dquat_t a_in, b_in, rot, trn, u1_a, u1_b;
  assign a_in.r = {a_real_zw, a_real_xy};
  assign a_in.d = {a_dual_zw, a_dual_xy};
  assign b_in.r = {b_real_zw, b_real_xy};
  assign b_in.d = {b_dual_zw, b_dual_xy};

  assign rot.r   = b_in.r;
  assign rot.d   = '0;
  assign trn.r.x = '0;
  assign trn.r.y = '0;
  assign trn.r.z = '0;
  assign trn.r.w = ONE;
  // halved translation, floor toward minus infinity
  assign trn.d.x = {b_in.d.x[31], b_in.d.x[31:1]};
  assign trn.d.y = {b_in.d.y[31], b_in.d.y[31:1]};
  assign trn.d.z = {b_in.d.z[31], b_in.d.z[31:1]};
  assign trn.d.w = '0;

  always_comb begin
    unique case (action)
      dqa_pkg::ACT_ROT_FIRST: begin
        u1_a = trn;
        u1_b = rot;
      end
      dqa_pkg::ACT_TR_FIRST: begin
        u1_a = rot;
        u1_b = trn;
      end
      default: begin
        u1_a = a_in;
        u1_b = b_in;
      end
    endcase
  end

  // sideband delay lines
  logic [2:0]      act_p [LL];
  dqa_pkg::dquat_t a_p   [2];
  dqa_pkg::dquat_t b_p   [2];
  always_ff @(posedge clk) begin
    if (en) begin
      act_p[0] <= action;
      for (int k = 1; k < LL; k++) begin
        act_p[k] <= act_p[k-1];
      end
      a_p[0] <= a_in;
      a_p[1] <= a_p[0];
      b_p[0] <= b_in;
      b_p[1] <= b_p[0];
    end
  end

  // first product: A*B, or T built from rotation and translation
  dqa_pkg::dquat_t x1;
  logic            s1;
  dqa_dq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul1 (
    .clk(clk), .en(en), .a(u1_a), .b(u1_b), .res(x1), .sat(s1)
  );

  dqa_pkg::dquat_t t2;
  logic            fa2;
  assign t2  = (act_p[1] == dqa_pkg::ACT_XFORM) ? b_p[1] : x1;
  assign fa2 = ((act_p[1] == dqa_pkg::ACT_ROT_FIRST) ||
                (act_p[1] == dqa_pkg::ACT_TR_FIRST)) ? s1 : 1'b0;

  // T*A
  dqa_pkg::dquat_t ta;
  logic            s2;
  dqa_dq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul2 (
    .clk(clk), .en(en), .a(t2), .b(a_p[1]), .res(ta), .sat(s2)
  );

  dqa_pkg::dquat_t   x1_p [4];
  logic              s1_p [4];
  dqa_pkg::dquat_t   t_p  [2];
  logic              fa_p [2];
  logic              fb_p [2];
  dqa_pkg::dq_flag_t dc;
  assign dc = dqa_pkg::dconj(t_p[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p[0] <= x1;
      s1_p[0] <= s1;
      for (int k = 1; k < 4; k++) begin
        x1_p[k] <= x1_p[k-1];
        s1_p[k] <= s1_p[k-1];
      end
      t_p[0]  <= t2;
      t_p[1]  <= t_p[0];
      fa_p[0] <= fa2;
      fa_p[1] <= fa_p[0];
      fb_p[0] <= fa_p[1] | s2 | dc.sat;
      fb_p[1] <= fb_p[0];
    end
  end

  // (T*A)*dc(T)
  dqa_pkg::dquat_t r3;
  logic            s3;
  dqa_dq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul3 (
    .clk(clk), .en(en), .a(ta), .b(dc.q), .res(r3), .sat(s3)
  );

  dqa_pkg::dquat_t dres6;
  logic            dsat6;
  assign dres6 = (act_p[5] == dqa_pkg::ACT_MUL) ? x1_p[3] : r3;
  assign dsat6 = (act_p[5] == dqa_pkg::ACT_MUL) ? s1_p[3] : (fb_p[1] | s3);

  dqa_pkg::dquat_t dres_p [PAD];
  logic            dsat_p [PAD];
  always_ff @(posedge clk) begin
    if (en) begin
      dres_p[0] <= dres6;
      dsat_p[0] <= dsat6;
      for (int k = 1; k < PAD; k++) begin
        dres_p[k] <= dres_p[k-1];
        dsat_p[k] <= dsat_p[k-1];
      end
    end
  end

  dqa_pkg::dquat_t lres;
  logic            lsat;
  logic            lzl;
  dqa_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk(clk), .en(en), .a(a_in), .b(b_in), .p(proportion),
    .res(lres), .sat(lsat), .zl(lzl)
  );

  // result select and output register
  dqa_pkg::dquat_t ores, ores_next;
  logic            osat, osat_next;
  logic            ozl, ozl_next;
  always_comb begin
    unique case (act_p[LL-1])
      dqa_pkg::ACT_MUL, dqa_pkg::ACT_XFORM, dqa_pkg::ACT_ROT_FIRST,
      dqa_pkg::ACT_TR_FIRST: begin
        ores_next = dres_p[PAD-1];
        osat_next = dsat_p[PAD-1];
        ozl_next  = 1'b0;
      end
      dqa_pkg::ACT_LERP: begin
        ores_next = lres;
        osat_next = lsat;
        ozl_next  = lzl;
      end
      default: begin
        ores_next = '0;
        osat_next = 1'b0;
        ozl_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ores <= ores_next;
      osat <= osat_next;
      ozl  <= ozl_next;
    end
  end

  assign res_real_xy = {ores.r.y, ores.r.x};
  assign res_real_zw = {ores.r.w, ores.r.z};
  assign res_dual_xy = {ores.d.y, ores.d.x};
  assign res_dual_zw = {ores.d.w, ores.d.z};
  assign saturated   = osat;
  assign zero_length = ozl;

endmodule

// ----- tb/sv/dual_quaternion_arith_unit_core_tb.sv -----
// Self-checking testbench for dual_quaternion_arith_unit_core.
// Depends on dqa_pkg and the RTL under hw/rtl; a built-in Q16.16 predictor
// computes each expected result, and a scoreboard class checks results in order.
`timescale 1ns / 1ps

module dual_quaternion_arith_unit_core_tb;
  import dqa_pkg::*;

  localparam int  NUM_RANDOM  = 800;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_WAIT  = LERP_LAT + 30;
  localparam logic [2:0] ACT_UNUSED = 3'd5;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] a [4];
    logic [63:0] b [4];
    logic [31:0] prop;
  } dq_item_t;

  typedef struct {
    logic [63:0] w [4];
    logic        sat;
    logic        zl;
  } dq_res_t;

  typedef struct {longint c [4];} qv_t;
  typedef struct {qv_t r; qv_t d;} dqv_t;

  class dq_scoreboard;
    dq_res_t expected_q [$];
    int      errors = 0;

    function longint rmul(longint x, longint y);
      longint p;
      p = x * y + (64'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
    endfunction

    function longint clamp(longint v, ref bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function qv_t unpack(logic [63:0] xy, logic [63:0] zw);
      qv_t q;
      q.c[0] = $signed(xy[31:0]);
      q.c[1] = $signed(xy[63:32]);
      q.c[2] = $signed(zw[31:0]);
      q.c[3] = $signed(zw[63:32]);
      return q;
    endfunction

    function qv_t ham(qv_t a, qv_t b);
      qv_t o;
      o.c[0] = rmul(a.c[3], b.c[0]) + rmul(a.c[0], b.c[3]) + rmul(a.c[1], b.c[2])
             - rmul(a.c[2], b.c[1]);
      o.c[1] = rmul(a.c[3], b.c[1]) - rmul(a.c[0], b.c[2]) + rmul(a.c[1], b.c[3])
             + rmul(a.c[2], b.c[0]);
      o.c[2] = rmul(a.c[3], b.c[2]) + rmul(a.c[0], b.c[1]) - rmul(a.c[1], b.c[0])
             + rmul(a.c[2], b.c[3]);
      o.c[3] = rmul(a.c[3], b.c[3]) - rmul(a.c[0], b.c[0]) - rmul(a.c[1], b.c[1])
             - rmul(a.c[2], b.c[2]);
      return o;
    endfunction

    function dqv_t dmul(dqv_t a, dqv_t b, ref bit f);
      dqv_t o;
      qv_t rr, rd, dr;
      rr = ham(a.r, b.r);
      rd = ham(a.r, b.d);
      dr = ham(a.d, b.r);
      for (int i = 0; i < 4; i++) begin
        o.r.c[i] = clamp(rr.c[i], f);
        o.d.c[i] = clamp(rd.c[i] + dr.c[i], f);
      end
      return o;
    endfunction

    function dqv_t xform(dqv_t a, dqv_t t, ref bit f);
      dqv_t ta, tc;
      ta = dmul(t, a, f);
      tc = t;
      for (int i = 0; i < 3; i++) tc.r.c[i] = clamp(-t.r.c[i], f);
      tc.d.c[3] = clamp(-t.d.c[3], f);
      return dmul(ta, tc, f);
    endfunction

    function bit [63:0] root(bit [63:0] n);
      bit [63:0] acc, bt;
      acc = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
        if (n >= acc + bt) begin
          n -= acc + bt;
          acc = (acc >> 1) + bt;
        end else begin
          acc >>= 1;
        end
        bt >>= 2;
      end
      return acc;
    endfunction

    function longint norm_div(longint c, bit [63:0] len, ref bit f);
      bit [63:0] mag, q;
      longint v;
      mag = 64'(c < 0 ? -c : c) << FRAC_BITS;
      q = (mag + (len >> 1)) / len;
      v = q;
      return clamp(c < 0 ? -v : v, f);
    endfunction

    function dq_res_t predict(dq_item_t it);
      dq_res_t e;
      dqv_t a, b, res, m, rot, tr, t;
      bit f, zl;
      longint one, p, q;
      bit [63:0] s, sq, len;
      f = 0;
      zl = 0;
      one = 64'sd1 <<< FRAC_BITS;
      a.r = unpack(it.a[0], it.a[1]);
      a.d = unpack(it.a[2], it.a[3]);
      b.r = unpack(it.b[0], it.b[1]);
      b.d = unpack(it.b[2], it.b[3]);
      for (int i = 0; i < 4; i++) begin
        res.r.c[i] = 0;
        res.d.c[i] = 0;
      end
      case (it.action)
        ACT_MUL: res = dmul(a, b, f);
        ACT_XFORM: res = xform(a, b, f);
        ACT_LERP: begin
          p = $signed(it.prop);
          q = one - p;
          s = 0;
          for (int i = 0; i < 4; i++) begin
            m.r.c[i] = clamp(rmul(q, a.r.c[i]) + rmul(p, b.r.c[i]), f);
            m.d.c[i] = clamp(rmul(q, a.d.c[i]) + rmul(p, b.d.c[i]), f);
          end
          for (int i = 0; i < 4; i++) begin
            sq = m.r.c[i] * m.r.c[i];
            s = (s > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s + sq;
          end
          len = root(s);
          if (len == 0) begin
            zl = 1;
            f = 0;
          end else begin
            for (int i = 0; i < 4; i++) begin
              res.r.c[i] = norm_div(m.r.c[i], len, f);
              res.d.c[i] = norm_div(m.d.c[i], len, f);
            end
          end
        end
        ACT_ROT_FIRST, ACT_TR_FIRST: begin
          rot.r = b.r;
          for (int i = 0; i < 4; i++) begin
            rot.d.c[i] = 0;
            tr.r.c[i] = 0;
          end
          tr.r.c[3] = one;
          for (int i = 0; i < 3; i++) tr.d.c[i] = b.d.c[i] >>> 1;
          tr.d.c[3] = 0;
          t = (it.action == ACT_ROT_FIRST) ? dmul(tr, rot, f) : dmul(rot, tr, f);
          res = xform(a, t, f);
        end
        default: ;
      endcase
      e.w[0] = {res.r.c[1][31:0], res.r.c[0][31:0]};
      e.w[1] = {res.r.c[3][31:0], res.r.c[2][31:0]};
      e.w[2] = {res.d.c[1][31:0], res.d.c[0][31:0]};
      e.w[3] = {res.d.c[3][31:0], res.d.c[2][31:0]};
      e.sat = f;
      e.zl = zl;
      return e;
    endfunction

    function void note_input(dq_item_t it);
      expected_q.push_back(predict(it));
    endfunction

    function void check_result(dq_res_t got);
      dq_res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.w[i] !== e.w[i]) begin
          $display("%0t: result word %0d expected %h actual %h", $time, i, e.w[i], got.w[i]);
          errors++;
        end
      if (got.sat !== e.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, e.sat, got.sat);
        errors++;
      end
      if (got.zl !== e.zl) begin
        $display("%0t: zero_length expected %b actual %b", $time, e.zl, got.zl);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] action;
  logic [63:0] a_real_xy, a_real_zw, a_dual_xy, a_dual_zw;
  logic [63:0] b_real_xy, b_real_zw, b_dual_xy, b_dual_zw;
  logic signed [31:0] proportion;
  logic [63:0] res_real_xy, res_real_zw, res_dual_xy, res_dual_zw;
  logic saturated, zero_length;

  dq_scoreboard sb = new();
  int  cycles = 0;
  int  stall_cnt = 0;
  bit  quiet = 0;

  dual_quaternion_arith_unit_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result monitor, stall drawn per transaction
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) begin
      dq_res_t got;
      got.w[0] = res_real_xy;
      got.w[1] = res_real_zw;
      got.w[2] = res_dual_xy;
      got.w[3] = res_dual_zw;
      got.sat = saturated;
      got.zl = zero_length;
      sb.check_result(got);
      stall_cnt = quiet ? 0 : $urandom_range(0, 9);
    end

  always @(negedge clk) begin
    out_stall <= (stall_cnt != 0);
    if (stall_cnt != 0) stall_cnt--;
  end

  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
      2: return 32'($signed($urandom_range(0, 32'h200)) - 32'sh100);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic dq_item_t rand_item();
    dq_item_t it;
    int kind;
    kind = $urandom_range(0, 9);
    kind = kind < 2 ? 0 : (kind < 8 ? 1 : (kind < 9 ? 2 : 3));
    it.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    for (int i = 0; i < 4; i++) begin
      it.a[i] = {rand_comp(kind), rand_comp(kind)};
      it.b[i] = {rand_comp(kind), rand_comp(kind)};
    end
    it.prop = (kind == 0) ? $urandom : rand_comp(1);
    if (it.action == ACT_LERP && $urandom_range(0, 9) == 0) begin
      it.a[0] = 0;
      it.a[1] = 0;
      it.prop = 0;
    end
    return it;
  endfunction

  task automatic send(dq_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action     <= it.action;
    a_real_xy  <= it.a[0];
    a_real_zw  <= it.a[1];
    a_dual_xy  <= it.a[2];
    a_dual_zw  <= it.a[3];
    b_real_xy  <= it.b[0];
    b_real_zw  <= it.b[1];
    b_dual_xy  <= it.b[2];
    b_dual_zw  <= it.b[3];
    proportion <= it.prop;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fixed(logic [2:0] act, logic [31:0] ca, logic [31:0] cb,
                            logic [31:0] p);
    dq_item_t it;
    it.action = act;
    for (int i = 0; i < 4; i++) begin
      it.a[i] = {ca, ca};
      it.b[i] = {cb, cb};
    end
    it.prop = p;
    send(it);
  endtask

  initial begin
    dq_item_t it;
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    action = ACT_MUL;
    {a_real_xy, a_real_zw, a_dual_xy, a_dual_zw} = '0;
    {b_real_xy, b_real_zw, b_dual_xy, b_dual_zw} = '0;
    proportion = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes on every action, zero length, unused codes
    for (int k = 0; k <= ACT_TR_FIRST; k++) begin
      send_fixed(3'(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_fixed(3'(k), 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF);
      send_fixed(3'(k), 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    end
    send_fixed(ACT_LERP, 32'h0, 32'h1234_5678, 32'h0);
    send_fixed(ACT_LERP, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_fixed(ACT_UNUSED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fixed(3'd6, 32'h1, 32'h1, 32'h1);
    send_fixed(3'd7, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == NUM_RANDOM / 2) wait_drained();
      it = rand_item();
      send(it);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- dual_quaternion_arith_unit_core.f -----
hw/rtl/dqa_pkg.sv
hw/rtl/dqa_dq_mul.sv
hw/rtl/dqa_lerp.sv
hw/rtl/dual_quaternion_arith_unit_core.sv
tb/sv/dual_quaternion_arith_unit_core_tb.sv
